>>> hw/rtl/i2dt_pkg.sv
package i2dt_pkg;

   localparam int VALUE_W  = 64;
   localparam int NDIGITS  = 20;
   localparam int BITCNT_W = 6;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               neg;
      logic [7:0]         cap;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       store;
      logic [4:0] position;
      logic [4:0] count;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_LEN,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/i2dt_if.sv
interface i2dt_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        is_signed;
   logic [7:0]  cap;

   modport source (output valid, output value, output is_signed, output cap, input ready);
   modport sink   (input valid, input value, input is_signed, input cap, output ready);
endinterface

interface i2dt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       store;
   logic [4:0] position;
   logic [4:0] count;
   logic       last;

   modport source (output valid, output ch, output store, output position, output count,
                   output last, input ready);
   modport sink   (input valid, input ch, input store, input position, input count,
                   input last, output ready);
endinterface

>>> hw/rtl/i2dt_front.sv
module i2dt_front import i2dt_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   i2dt_req_if.sink req_bus,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               push, pop, neg;
   cmd_type            new_cmd;

   // classify: sign and unsigned magnitude
   always_comb begin
      neg          = req_bus.is_signed & req_bus.value[VALUE_W-1];
      new_cmd.neg  = neg;
      new_cmd.mag  = neg ? (~req_bus.value + VALUE_W'(1)) : req_bus.value;
      new_cmd.cap  = req_bus.cap;
   end

   assign req_bus.ready = (fill_ff != CNT_W'(DEPTH));
   assign cmd_valid     = (fill_ff != '0);
   assign cmd           = entry_ff[rd_ptr_ff];
   assign push          = req_bus.valid & req_bus.ready;
   assign pop           = cmd_valid & cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("queue fill above depth");

   a_pop_drops: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> fill_ff == $past(fill_ff) - CNT_W'(1))
      else $error("queue fill did not drop on pop");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> fill_ff == $past(fill_ff) + CNT_W'(1))
      else $error("queue fill did not grow on push");

endmodule

>>> hw/rtl/i2dt_back.sv
module i2dt_back import i2dt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_ready,
   i2dt_rsp_if.source rsp_bus
);

   state_type                 state_ff, state_in;
   logic [BITCNT_W-1:0]       bitcnt_ff, bitcnt_in;
   logic [VALUE_W-1:0]        mag_ff, mag_in;
   logic [NDIGITS-1:0][3:0]   digits_ff, digits_in;
   logic                      neg_ff, neg_in;
   logic [7:0]                cap_ff, cap_in;
   logic [4:0]                ndig_ff, ndig_in;
   logic [4:0]                endpos_ff, endpos_in;
   logic [4:0]                pos_ff, pos_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_ff, out_in;

   logic [NDIGITS-1:0][3:0]   adj;
   logic [4:0]                ndig_w, written, dig_idx;
   logic [7:0]                avail;
   logic                      slot_free;
   rsp_type                   res;

   assign slot_free = !out_valid_ff || rsp_bus.ready;

   // double dabble correction, one per digit
   always_comb begin
      for (int d = 0; d < NDIGITS; d++) begin
         adj[d] = (digits_ff[d] >= 4'd5) ? digits_ff[d] + 4'd3 : digits_ff[d];
      end
   end

   // significant digit count
   always_comb begin
      ndig_w = 5'd1;
      for (int d = 1; d < NDIGITS; d++) begin
         if (digits_ff[d] != 4'd0) begin
            ndig_w = 5'(d + 1);
         end
      end
      avail   = cap_ff - {7'd0, neg_ff} - 8'd1;
      written = (avail < {3'd0, ndig_w}) ? avail[4:0] : ndig_w;
   end

   // result for the current position
   always_comb begin
      dig_idx      = ndig_ff + {4'd0, neg_ff} - 5'd1 - pos_ff;
      res.ch       = CHAR_NUL;
      res.store    = 1'b1;
      res.position = pos_ff;
      res.count    = 5'd0;
      res.last     = 1'b0;
      if (cap_ff == 8'd0) begin
         res.store    = 1'b0;
         res.position = 5'd0;
         res.last     = 1'b1;
      end else if (neg_ff && cap_ff == 8'd1) begin
         res.position = 5'd0;
         res.last     = 1'b1;
      end else if (neg_ff && pos_ff == 5'd0) begin
         res.ch = CHAR_MINUS;
      end else if (pos_ff < endpos_ff) begin
         res.ch = CHAR_ZERO + {4'd0, digits_ff[dig_idx]};
      end else begin
         res.count = pos_ff;
         res.last  = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      bitcnt_in    = bitcnt_ff;
      mag_in       = mag_ff;
      digits_in    = digits_ff;
      neg_in       = neg_ff;
      cap_in       = cap_ff;
      ndig_in      = ndig_ff;
      endpos_in    = endpos_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_in       = out_ff;
      cmd_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               mag_in    = cmd.mag;
               neg_in    = cmd.neg;
               cap_in    = cmd.cap;
               digits_in = '0;
               bitcnt_in = '0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            digits_in = (NDIGITS*4)'({adj, mag_ff[VALUE_W-1]});
            mag_in    = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff + BITCNT_W'(1);
            if (bitcnt_ff == BITCNT_W'(VALUE_W - 1)) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            ndig_in   = ndig_w;
            endpos_in = {4'd0, neg_ff} + written;
            pos_in    = 5'd0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_in       = res;
               pos_in       = pos_ff + 5'd1;
               if (res.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bitcnt_ff <= bitcnt_in;
      mag_ff    <= mag_in;
      digits_ff <= digits_in;
      neg_ff    <= neg_in;
      cap_ff    <= cap_in;
      ndig_ff   <= ndig_in;
      endpos_ff <= endpos_in;
      pos_ff    <= pos_in;
      out_ff    <= out_in;
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.ch       = out_ff.ch;
   assign rsp_bus.store    = out_ff.store;
   assign rsp_bus.position = out_ff.position;
   assign rsp_bus.count    = out_ff.count;
   assign rsp_bus.last     = out_ff.last;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |-> state_ff == ST_IDLE)
      else $error("request popped while busy");

   a_term_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.last && out_ff.store) |->
         (out_ff.ch == CHAR_NUL && out_ff.count == out_ff.position))
      else $error("terminator count mismatch");

   a_mid_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.last) |-> (out_ff.store && out_ff.count == 5'd0))
      else $error("bad non-final result");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.position <= 5'(NDIGITS))
      else $error("position out of range");

endmodule

>>> hw/rtl/int64_to_decimal_text.sv
// Channel   Dir   Payload                                  Handshake
// req_bus   in    value[63:0] is_signed cap[7:0]           valid/ready
// rsp_bus   out   ch[7:0] store position[4:0] count[4:0] last  valid/ready
//
// Each request passes through the back end as pop, 64 double dabble shifts and
// digit count; the back end then emits 1 to 21 results, one whenever the output slot is free.
// The front queue keeps accepting requests while the back end converts, until it is full.
// Reset is synchronous and clears queue pointers, FSM state and output valid.
// Results hold in the output register while rsp_bus.ready is low.
module int64_to_decimal_text import i2dt_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   i2dt_req_if.sink   req_bus,
   i2dt_rsp_if.source rsp_bus
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   i2dt_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   i2dt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
